// File: hdl/tpp_pkg.sv
package tpp_pkg;

	localparam int CW     = 32;
	localparam int RW     = 31;
	localparam int PW     = 2 * CW;
	localparam int AW     = 3;
	localparam int DW     = 32;
	localparam int QW     = CW + 1;
	localparam int SW     = CW + 3;

	localparam logic [RW-1:0] MAJOR_RST = RW'(327680);
	localparam logic [RW-1:0] TUBE_RST  = RW'(65536);

	localparam logic REG_MAJOR = 1'b0;
	localparam logic REG_TUBE  = 1'b1;

	typedef struct packed {
		logic [CW-1:0] ax;
		logic [CW-1:0] ay;
		logic [CW-1:0] az;
		logic          xneg;
		logic          yneg;
		logic          zneg;
		logic          axis;
	} front_t;

	typedef struct packed {
		logic [CW-1:0] ax;
		logic [CW-1:0] ay;
		logic [CW-1:0] az;
		logic [CW-1:0] ad;
		logic [CW-1:0] rho;
		logic          xneg;
		logic          yneg;
		logic          zneg;
		logic          dneg;
		logic          axis;
		logic          bb;
		logic          in_tube;
	} mid_t;

	typedef struct packed {
		logic [CW-1:0] ax;
		logic [CW-1:0] ay;
		logic [CW-1:0] rho;
		logic          xneg;
		logic          yneg;
		logic          dneg;
		logic          axis;
		logic          bb;
		logic          in_tube;
	} scl_t;

	typedef struct packed {
		logic [CW-1:0] pz;
		logic          xneg;
		logic          prhoneg;
		logic          axis;
		logic          bb;
		logic          in_tube;
	} tail_t;

	function automatic logic [CW-1:0] mag(input logic [CW-1:0] v);
		return v[CW-1] ? CW'(-v) : v;
	endfunction

	function automatic logic [CW-1:0] sat(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] hi;
		logic signed [SW-1:0] lo;
		hi = SW'({1'b0, {(CW-1){1'b1}}});
		lo = -hi - SW'(1);
		if (v > hi) begin
			return hi[CW-1:0];
		end else if (v < lo) begin
			return lo[CW-1:0];
		end
		return v[CW-1:0];
	endfunction

	function automatic logic [CW-1:0] apply_sign(input logic neg, input logic [QW-1:0] q);
		logic signed [SW-1:0] v;
		v = neg ? -SW'(q) : SW'(q);
		return sat(v);
	endfunction

endpackage

// File: hdl/tpp_sqrt.sv
module tpp_sqrt #(
	parameter int RAD_W  = 64,
	parameter int SIDE_W = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_vld,
	input  logic [RAD_W-1:0]     in_rad,
	input  logic [SIDE_W-1:0]    in_side,
	output logic                 out_vld,
	output logic [RAD_W/2-1:0]   out_root,
	output logic [SIDE_W-1:0]    out_side
);

	localparam int RES_W  = RAD_W / 2;
	localparam int STAGES = RAD_W / 4;
	localparam int REM_W  = RES_W + 4;

	logic [REM_W-1:0]  rem_s  [0:STAGES];
	logic [RES_W-1:0]  res_s  [0:STAGES];
	logic [RAD_W-1:0]  rad_s  [0:STAGES];
	logic [SIDE_W-1:0] side_s [0:STAGES];
	logic [STAGES:0]   vld_s;

	assign rem_s[0]  = '0;
	assign res_s[0]  = '0;
	assign rad_s[0]  = in_rad;
	assign side_s[0] = in_side;
	assign vld_s[0]  = in_vld;

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		logic [REM_W-1:0] rem_n;
		logic [RES_W-1:0] res_n;
		logic [REM_W-1:0] trial;

		always_comb begin
			rem_n = rem_s[k];
			res_n = res_s[k];
			trial = '0;
			for (int j = 0; j < 2; j++) begin
				rem_n = {rem_n[REM_W-3:0], rad_s[k][RAD_W-1-2*(2*k+j) -: 2]};
				trial = REM_W'({res_n, 2'b01});
				if (rem_n >= trial) begin
					rem_n = rem_n - trial;
					res_n = {res_n[RES_W-2:0], 1'b1};
				end else begin
					res_n = {res_n[RES_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= rem_n;
			res_s[k+1]  <= res_n;
			rad_s[k+1]  <= rad_s[k];
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_vld  = vld_s[STAGES];
	assign out_root = res_s[STAGES];
	assign out_side = side_s[STAGES];

endmodule

// File: hdl/tpp_div.sv
module tpp_div #(
	parameter int NUM_W  = 64,
	parameter int DEN_W  = 32,
	parameter int Q_W    = 32,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  logic [NUM_W-1:0]  in_num,
	input  logic [DEN_W-1:0]  in_den,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_vld,
	output logic [Q_W:0]      out_quo,
	output logic [SIDE_W-1:0] out_side
);

	localparam int STAGES = Q_W / 2;

	logic [DEN_W-1:0]  rem_s  [0:STAGES];
	logic [DEN_W-1:0]  den_s  [0:STAGES];
	logic [Q_W-1:0]    low_s  [0:STAGES];
	logic [Q_W-1:0]    quo_s  [0:STAGES];
	logic [SIDE_W-1:0] side_s [0:STAGES];
	logic [STAGES:0]   vld_s;

	logic [Q_W:0]      quo_sr;
	logic [SIDE_W-1:0] side_sr;
	logic              vld_sr;

	assign rem_s[0]  = DEN_W'(in_num >> Q_W);
	assign den_s[0]  = in_den;
	assign low_s[0]  = in_num[Q_W-1:0];
	assign quo_s[0]  = '0;
	assign side_s[0] = in_side;
	assign vld_s[0]  = in_vld;

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		logic [DEN_W:0]   part;
		logic [DEN_W-1:0] rem_n;
		logic [Q_W-1:0]   quo_n;

		always_comb begin
			rem_n = rem_s[k];
			quo_n = quo_s[k];
			part  = '0;
			for (int j = 0; j < 2; j++) begin
				part = {rem_n, low_s[k][Q_W-1-(2*k+j)]};
				if (part >= {1'b0, den_s[k]}) begin
					part  = part - {1'b0, den_s[k]};
					quo_n = {quo_n[Q_W-2:0], 1'b1};
				end else begin
					quo_n = {quo_n[Q_W-2:0], 1'b0};
				end
				rem_n = part[DEN_W-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= rem_n;
			den_s[k+1]  <= den_s[k];
			low_s[k+1]  <= low_s[k];
			quo_s[k+1]  <= quo_n;
			side_s[k+1] <= side_s[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sr <= 1'b0;
		end else begin
			vld_sr <= vld_s[STAGES];
		end
	end

	// round half up: remainder at least half the divisor
	always_ff @(posedge clk) begin
		quo_sr  <= {1'b0, quo_s[STAGES]}
			+ (Q_W+1)'({rem_s[STAGES], 1'b0} >= {1'b0, den_s[STAGES]});
		side_sr <= side_s[STAGES];
	end

	assign out_vld  = vld_sr;
	assign out_quo  = quo_sr;
	assign out_side = side_sr;

endmodule

// File: hdl/torus_point_project.sv
// Projects each point onto the surface of a torus centred at the origin with its axis
// along z. One point is taken in every clock cycle and busy stays low; the result
// appears on the result ports with done high for one cycle. Each point passes through
// the two 16-stage square root pipelines and the two 17-stage dividing pipelines in
// series, plus the multiply and add stages between them. The receiver cannot stall
// the block. The user must write radii through the register port only while no
// point is in flight; the block itself does not enforce this.
module torus_point_project
	import tpp_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic [CW-1:0] pos_x,
	input  logic [CW-1:0] pos_y,
	input  logic [CW-1:0] pos_z,
	output logic          done,
	output logic [CW-1:0] proj_x,
	output logic [CW-1:0] proj_y,
	output logic [CW-1:0] proj_z,
	output logic          is_inside,
	output logic          on_axis,
	output logic          on_backbone,
	output logic          bad_config,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [AW-1:0] paddr,
	input  logic [DW-1:0] pwdata,
	output logic [DW-1:0] prdata,
	output logic          pready
);

	logic [RW-1:0]   major_q;
	logic [RW-1:0]   tube_q;
	logic [2*RW-1:0] wsq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			major_q <= MAJOR_RST;
			tube_q  <= TUBE_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_MAJOR: major_q <= pwdata[RW-1:0];
				REG_TUBE:  tube_q  <= pwdata[RW-1:0];
				default:   major_q <= major_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		wsq_q <= tube_q * tube_q;
	end

	assign prdata = (paddr[2] == REG_TUBE) ? DW'(tube_q) : DW'(major_q);
	assign pready = 1'b1;
	assign busy   = 1'b0;

	front_t        f_s1, f_s2, f_s3, f_r;
	logic          vld_s1, vld_s2, vld_s3, vld_r;
	logic [PW-1:0] sqx_s2, sqy_s2, rad_s3;
	logic [CW-1:0] rho_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		f_s1.ax   <= mag(pos_x);
		f_s1.ay   <= mag(pos_y);
		f_s1.az   <= mag(pos_z);
		f_s1.xneg <= pos_x[CW-1];
		f_s1.yneg <= pos_y[CW-1];
		f_s1.zneg <= pos_z[CW-1];
		f_s1.axis <= (pos_x == '0) && (pos_y == '0);
		sqx_s2    <= f_s1.ax * f_s1.ax;
		sqy_s2    <= f_s1.ay * f_s1.ay;
		f_s2      <= f_s1;
		rad_s3    <= sqx_s2 + sqy_s2;
		f_s3      <= f_s2;
	end

	tpp_sqrt #(.RAD_W(PW), .SIDE_W($bits(front_t))) u_sqrt_rho (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s3),
		.in_rad   (rad_s3),
		.in_side  (f_s3),
		.out_vld  (vld_r),
		.out_root (rho_r),
		.out_side (f_r)
	);

	logic [CW-1:0] maj_w;
	mid_t          m_s4, m_s5, m_s6, m_r, m6_n;
	logic          vld_s4, vld_s5, vld_s6, vld_m;
	logic [PW-1:0] ad2_s5, az2_s5, sum_n, rad_s6;
	logic [CW-1:0] dist_r;

	assign maj_w = CW'(major_q);
	assign sum_n = ad2_s5 + az2_s5;

	always_comb begin
		m6_n         = m_s5;
		m6_n.bb      = sum_n == '0;
		m6_n.in_tube = sum_n <= PW'(wsq_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s4 <= vld_r;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		m_s4.ax      <= f_r.ax;
		m_s4.ay      <= f_r.ay;
		m_s4.az      <= f_r.az;
		m_s4.ad      <= (rho_r >= maj_w) ? rho_r - maj_w : maj_w - rho_r;
		m_s4.rho     <= rho_r;
		m_s4.xneg    <= f_r.xneg;
		m_s4.yneg    <= f_r.yneg;
		m_s4.zneg    <= f_r.zneg;
		m_s4.dneg    <= rho_r < maj_w;
		m_s4.axis    <= f_r.axis;
		m_s4.bb      <= 1'b0;
		m_s4.in_tube <= 1'b0;
		ad2_s5       <= m_s4.ad * m_s4.ad;
		az2_s5       <= m_s4.az * m_s4.az;
		m_s5         <= m_s4;
		rad_s6       <= sum_n;
		m_s6         <= m6_n;
	end

	tpp_sqrt #(.RAD_W(PW), .SIDE_W($bits(mid_t))) u_sqrt_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s6),
		.in_rad   (rad_s6),
		.in_side  (m_s6),
		.out_vld  (vld_m),
		.out_root (dist_r),
		.out_side (m_r)
	);

	scl_t          c_s7, c_r;
	logic          zneg_s7, zneg_r;
	logic          vld_s7, vld_d, vld_z;
	logic [PW-1:0] nd_s7, nz_s7;
	logic [CW-1:0] dist_s7;
	logic [QW-1:0] qd_r, qz_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else begin
			vld_s7 <= vld_m;
		end
	end

	always_ff @(posedge clk) begin
		nd_s7        <= tube_q * m_r.ad;
		nz_s7        <= tube_q * m_r.az;
		dist_s7      <= dist_r;
		zneg_s7      <= m_r.zneg;
		c_s7.ax      <= m_r.ax;
		c_s7.ay      <= m_r.ay;
		c_s7.rho     <= m_r.rho;
		c_s7.xneg    <= m_r.xneg;
		c_s7.yneg    <= m_r.yneg;
		c_s7.dneg    <= m_r.dneg;
		c_s7.axis    <= m_r.axis;
		c_s7.bb      <= m_r.bb;
		c_s7.in_tube <= m_r.in_tube;
	end

	tpp_div #(.NUM_W(PW), .DEN_W(CW), .Q_W(CW), .SIDE_W($bits(scl_t))) u_div_d (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s7),
		.in_num   (nd_s7),
		.in_den   (dist_s7),
		.in_side  (c_s7),
		.out_vld  (vld_d),
		.out_quo  (qd_r),
		.out_side (c_r)
	);

	tpp_div #(.NUM_W(PW), .DEN_W(CW), .Q_W(CW), .SIDE_W(1)) u_div_z (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s7),
		.in_num   (nz_s7),
		.in_den   (dist_s7),
		.in_side  (zneg_s7),
		.out_vld  (vld_z),
		.out_quo  (qz_r),
		.out_side (zneg_r)
	);

	logic [QW-1:0] maj_q33;
	logic [QW-1:0] sum_p, dif_p, dif_n;
	logic [CW-1:0] aprho_s8, rho_s8, ax_s8, ay_s8;
	logic          yneg_s8, yneg_s9, yneg_r;
	tail_t         t_s8, t_s9, t_r;
	logic          vld_s8, vld_s9, vld_x, vld_y;
	logic [PW-1:0] nx_s9, ny_s9;
	logic [CW-1:0] rho_s9;
	logic [QW-1:0] qx_r, qy_r;

	assign maj_q33 = QW'(major_q);
	assign sum_p   = maj_q33 + qd_r;
	assign dif_p   = maj_q33 - qd_r;
	assign dif_n   = qd_r - maj_q33;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			vld_s8 <= vld_d;
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (!c_r.dneg) begin
			aprho_s8     <= sum_p[CW-1:0];
			t_s8.prhoneg <= 1'b0;
		end else if (qd_r > maj_q33) begin
			aprho_s8     <= dif_n[CW-1:0];
			t_s8.prhoneg <= 1'b1;
		end else begin
			aprho_s8     <= dif_p[CW-1:0];
			t_s8.prhoneg <= 1'b0;
		end
		t_s8.pz      <= apply_sign(zneg_r, qz_r);
		t_s8.xneg    <= c_r.xneg;
		t_s8.axis    <= c_r.axis;
		t_s8.bb      <= c_r.bb;
		t_s8.in_tube <= c_r.in_tube;
		yneg_s8      <= c_r.yneg;
		rho_s8       <= c_r.rho;
		ax_s8        <= c_r.ax;
		ay_s8        <= c_r.ay;
		nx_s9        <= ax_s8 * aprho_s8;
		ny_s9        <= ay_s8 * aprho_s8;
		rho_s9       <= rho_s8;
		t_s9         <= t_s8;
		yneg_s9      <= yneg_s8 ^ t_s8.prhoneg;
	end

	tpp_div #(.NUM_W(PW), .DEN_W(CW), .Q_W(CW), .SIDE_W($bits(tail_t))) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s9),
		.in_num   (nx_s9),
		.in_den   (rho_s9),
		.in_side  (t_s9),
		.out_vld  (vld_x),
		.out_quo  (qx_r),
		.out_side (t_r)
	);

	tpp_div #(.NUM_W(PW), .DEN_W(CW), .Q_W(CW), .SIDE_W(1)) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s9),
		.in_num   (ny_s9),
		.in_den   (rho_s9),
		.in_side  (yneg_s9),
		.out_vld  (vld_y),
		.out_quo  (qy_r),
		.out_side (yneg_r)
	);

	logic [CW-1:0] px_s10, py_s10, pz_s10;
	logic          inside_s10, axis_s10, bb_s10, bad_s10, vld_s10;
	logic          zero_n;

	assign zero_n = t_r.axis || t_r.bb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
		end else begin
			vld_s10 <= vld_x;
		end
	end

	always_ff @(posedge clk) begin
		px_s10     <= zero_n ? '0 : apply_sign(t_r.xneg ^ t_r.prhoneg, qx_r);
		py_s10     <= zero_n ? '0 : apply_sign(yneg_r, qy_r);
		pz_s10     <= zero_n ? '0 : t_r.pz;
		inside_s10 <= t_r.in_tube;
		axis_s10   <= t_r.axis;
		bb_s10     <= t_r.bb;
		bad_s10    <= tube_q > major_q;
	end

	assign done        = vld_s10;
	assign proj_x      = px_s10;
	assign proj_y      = py_s10;
	assign proj_z      = pz_s10;
	assign is_inside   = inside_s10;
	assign on_axis     = axis_s10;
	assign on_backbone = bb_s10;
	assign bad_config  = bad_s10;

	a_bb_inside: assert property (@(posedge clk) disable iff (!arst_n)
		done && on_backbone |-> is_inside)
		else $error("backbone point not flagged inside");

	a_zero_proj: assert property (@(posedge clk) disable iff (!arst_n)
		done && (on_axis || on_backbone) |-> proj_x == '0 && proj_y == '0 && proj_z == '0)
		else $error("degenerate point with nonzero projection");

	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_d == vld_z) && (vld_x == vld_y))
		else $error("paired dividers out of step");

endmodule
